### design/fba_pkg.sv
// Shared types, codes and field widths for the frame bitmap allocator.
`timescale 1ns / 1ps

package fba_pkg;

   // Fixed field widths
   localparam int ADDR_W  = 32;
   localparam int LIMIT_W = 13;
   localparam int GRANT_W = 12;

   // Action codes
   localparam logic [1:0] ACT_MARK  = 2'd0;
   localparam logic [1:0] ACT_FREE  = 2'd1;
   localparam logic [1:0] ACT_TEST  = 2'd2;
   localparam logic [1:0] ACT_ALLOC = 2'd3;

   // Status codes
   localparam logic [1:0] STAT_OK     = 2'd0;
   localparam logic [1:0] STAT_RANGE  = 2'd1;
   localparam logic [1:0] STAT_NOFREE = 2'd2;

   typedef struct packed {
      logic [1:0]        action;
      logic [ADDR_W-1:0] frame_address;
   } req_type;

   typedef struct packed {
      logic               in_use;
      logic [GRANT_W-1:0] frame_number;
      logic [1:0]         status;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_OFFSET,
      ST_ACCESS,
      ST_RESPOND
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic capture;
      logic decode;
      logic clear_wr;
      logic scan_step;
      logic rd_item;
      logic alloc_wr;
      logic take_offset;
      logic access;
      logic set_range;
      logic set_nofree;
      logic rsp_load;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic [1:0] action;
      logic       out_of_range;
      logic       scan_done;
      logic       word_full;
      logic       clear_last;
   } stat_type;

endpackage

### design/frame_bitmap_allocator_unit.sv
// Top level of the frame bitmap allocator: controller, datapath and checks.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+-------------------------------
//   req     | in        | req_valid / req_ready      | action, frame_address
//   rsp     | out       | rsp_valid / rsp_ready      | in_use, frame_number, status
//   csr     | in        | csr_write_enable, no wait  | frame count (13 bits)
//
// One item at a time. Mark, free and test pass through decode, offset, access and respond;
// an out-of-range frame goes from decode straight to respond. Allocate reads and then checks
// one whole word at a time until it finds a clear bit or runs out of whole words, as set by
// the single read port of the bitmap memory and its registered read.
// After reset a clearing pass writes one bitmap word per cycle, all WORD_COUNT words
// (128 at the defaults), with req_ready low. A new item is taken while a result
// waits; a stalled result holds the next one in the respond step.
`timescale 1ns / 1ps

module frame_bitmap_allocator_unit #(
   parameter int NUM_FRAMES = 4096,
   parameter int PAGE_BYTES = 4096,
   parameter int WORD_BITS  = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  fba_pkg::req_type            req_payload,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output fba_pkg::rsp_type            rsp_payload,
   input  logic                        csr_write_enable,
   input  logic [fba_pkg::LIMIT_W-1:0] csr_write_data
);
   import fba_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   fba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   fba_dpath #(
      .NUM_FRAMES (NUM_FRAMES),
      .PAGE_BYTES (PAGE_BYTES),
      .WORD_BITS  (WORD_BITS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_payload      (req_payload),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // No transfer right after reset, when the clearing pass starts
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_ready)
      else $error("item accepted during bitmap clearing");

   // One item in flight: ready drops after a transfer
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second item accepted while one is at work");

   // A failed allocate grants nothing
   a_nofree_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status == STAT_NOFREE) |->
         (rsp_payload.frame_number == '0 && !rsp_payload.in_use))
      else $error("no-free result carries a frame");

   // Status code three is never produced
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.status == STAT_OK || rsp_payload.status == STAT_RANGE ||
                     rsp_payload.status == STAT_NOFREE))
      else $error("undefined status code");

endmodule

### design/fba_dpath.sv
// Datapath: bitmap memory, frame decode, word scan and result registers.
`timescale 1ns / 1ps

module fba_dpath #(
   parameter int NUM_FRAMES = 4096,
   parameter int PAGE_BYTES = 4096,
   parameter int WORD_BITS  = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  fba_pkg::cmd_type                cmd,
   output fba_pkg::stat_type               stat,
   input  fba_pkg::req_type                req_payload,
   output fba_pkg::rsp_type                rsp_payload,
   input  logic                            csr_write_enable,
   input  logic [fba_pkg::LIMIT_W-1:0]     csr_write_data
);
   import fba_pkg::*;

   localparam int WORD_COUNT = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
   localparam int WIDX_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam int OFF_W      = $clog2(WORD_BITS);
   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
   localparam int FRAME_W    = ADDR_W - PAGE_SHIFT;
   localparam int CNT_W      = (WIDX_W + 1 > LIMIT_W) ? WIDX_W + 1 : LIMIT_W;
   // Reciprocal for exact division of a 13-bit value by WORD_BITS (up to 64)
   localparam int RECIP_SHIFT = LIMIT_W + 6;
   localparam int RECIP_MULT  = ((1 << RECIP_SHIFT) + WORD_BITS - 1) / WORD_BITS;
   localparam logic [LIMIT_W-1:0] WORD_BITS_L = LIMIT_W'(WORD_BITS);
   localparam logic [WORD_BITS-1:0] WORD_ONES = '1;

   // Quotient by WORD_BITS through multiply and shift
   function automatic logic [LIMIT_W-1:0] div_word(input logic [LIMIT_W-1:0] value);
      logic [31:0] prod;
      prod = 32'(value) * 32'(RECIP_MULT);
      return LIMIT_W'(prod >> RECIP_SHIFT);
   endfunction

   logic [WORD_BITS-1:0] mem [WORD_COUNT];

   logic [LIMIT_W-1:0]   csr_ff;
   logic [FRAME_W-1:0]   frame_ff;
   logic [1:0]           action_ff;
   logic [LIMIT_W-1:0]   q_ff;
   logic [LIMIT_W-1:0]   whole_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic [CNT_W-1:0]     cnt_in;
   logic [LIMIT_W-1:0]   base_ff;
   logic [OFF_W-1:0]     off_ff;
   logic [WORD_BITS-1:0] rd_data_ff;
   rsp_type              res_ff;
   rsp_type              res_in;
   rsp_type              rsp_ff;

   logic [LIMIT_W-1:0]   limit;
   logic [OFF_W-1:0]     zero_pos;
   logic [LIMIT_W-1:0]   grant;
   logic [WIDX_W-1:0]    rd_addr;
   logic [WIDX_W-1:0]    wr_addr;
   logic [WORD_BITS-1:0] wr_data;
   logic                 wr_en;
   logic [LIMIT_W-1:0]   off_full;

   // Saturate the frame count at capacity
   assign limit = (32'(csr_ff) > 32'(NUM_FRAMES)) ? LIMIT_W'(NUM_FRAMES) : csr_ff;

   // Find the lowest clear bit of the word just read
   always_comb begin
      zero_pos = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (!rd_data_ff[i]) begin
            zero_pos = OFF_W'(i);
         end
      end
   end

   assign grant    = base_ff + LIMIT_W'(zero_pos);
   assign off_full = frame_ff[LIMIT_W-1:0] - q_ff * WORD_BITS_L;

   // Select memory addresses and write data
   always_comb begin
      rd_addr = cmd.rd_item ? WIDX_W'(q_ff) : WIDX_W'(cnt_ff);
      wr_addr = cmd.access ? WIDX_W'(q_ff) : WIDX_W'(cnt_ff);
      wr_en   = cmd.clear_wr || cmd.alloc_wr ||
                (cmd.access && (action_ff == ACT_MARK || action_ff == ACT_FREE));
      if (cmd.clear_wr) begin
         wr_data = '0;
      end else if (cmd.alloc_wr) begin
         wr_data = rd_data_ff | (WORD_BITS'(1) << zero_pos);
      end else if (action_ff == ACT_MARK) begin
         wr_data = rd_data_ff | (WORD_BITS'(1) << off_ff);
      end else begin
         wr_data = rd_data_ff & ~(WORD_BITS'(1) << off_ff);
      end
   end

   // Bitmap memory with registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // Frame count register
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= LIMIT_W'(4096);
      end else if (csr_write_enable) begin
         csr_ff <= csr_write_data;
      end
   end

   // Scan and clear counter
   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.decode) begin
         cnt_in = '0;
      end else if (cmd.clear_wr || cmd.scan_step) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // Item registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         frame_ff  <= req_payload.frame_address[ADDR_W-1:PAGE_SHIFT];
         action_ff <= req_payload.action;
      end
      if (cmd.decode) begin
         q_ff     <= div_word(frame_ff[LIMIT_W-1:0]);
         whole_ff <= div_word(limit);
         base_ff  <= '0;
      end else if (cmd.scan_step) begin
         base_ff  <= base_ff + WORD_BITS_L;
      end
      if (cmd.take_offset) begin
         off_ff <= off_full[OFF_W-1:0];
      end
   end

   // Build the result
   always_comb begin
      res_in = res_ff;
      if (cmd.set_range) begin
         res_in.in_use       = (action_ff == ACT_TEST);
         res_in.frame_number = '0;
         res_in.status       = STAT_RANGE;
      end else if (cmd.set_nofree) begin
         res_in.in_use       = 1'b0;
         res_in.frame_number = '0;
         res_in.status       = STAT_NOFREE;
      end else if (cmd.alloc_wr) begin
         res_in.in_use       = 1'b0;
         res_in.frame_number = grant[GRANT_W-1:0];
         res_in.status       = STAT_OK;
      end else if (cmd.access) begin
         res_in.in_use       = (action_ff == ACT_TEST) && rd_data_ff[off_ff];
         res_in.frame_number = '0;
         res_in.status       = STAT_OK;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
      if (cmd.rsp_load) begin
         rsp_ff <= res_ff;
      end
   end

   assign rsp_payload = rsp_ff;

   // Report status to the controller
   assign stat.action       = action_ff;
   assign stat.out_of_range = (32'(frame_ff) >= 32'(limit));
   assign stat.scan_done    = (cnt_ff == CNT_W'(whole_ff));
   assign stat.word_full    = (rd_data_ff == WORD_ONES);
   assign stat.clear_last   = (cnt_ff == CNT_W'(WORD_COUNT - 1));

endmodule

### design/fba_ctrl.sv
// Controller: sequences clearing, decode, allocate scan, bit access and response.
`timescale 1ns / 1ps

module fba_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  fba_pkg::stat_type  stat,
   output fba_pkg::cmd_type   cmd
);
   import fba_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   // State and response valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (stat.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cmd.decode = 1'b1;
            if (stat.action == ACT_ALLOC) begin
               state_in = ST_SCAN_RD;
            end else if (stat.out_of_range) begin
               cmd.set_range = 1'b1;
               state_in      = ST_RESPOND;
            end else begin
               state_in = ST_OFFSET;
            end
         end
         ST_SCAN_RD: begin
            if (stat.scan_done) begin
               cmd.set_nofree = 1'b1;
               state_in       = ST_RESPOND;
            end else begin
               state_in = ST_SCAN_CHK;
            end
         end
         ST_SCAN_CHK: begin
            if (!stat.word_full) begin
               cmd.alloc_wr = 1'b1;
               state_in     = ST_RESPOND;
            end else begin
               cmd.scan_step = 1'b1;
               state_in      = ST_SCAN_RD;
            end
         end
         ST_OFFSET: begin
            cmd.take_offset = 1'b1;
            cmd.rd_item     = 1'b1;
            state_in        = ST_ACCESS;
         end
         ST_ACCESS: begin
            cmd.access  = 1'b1;
            cmd.rd_item = 1'b1;
            state_in    = ST_RESPOND;
         end
         ST_RESPOND: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### tb/frame_bitmap_allocator_unit_tb.sv
// Self-checking testbench for the frame bitmap allocator unit.
`timescale 1ns / 1ps

module frame_bitmap_allocator_unit_tb;
   import fba_pkg::*;

   localparam int NUM_FRAMES = 4096;
   localparam int PAGE_BYTES = 4096;
   localparam int WORD_BITS  = 32;
   localparam int WORD_COUNT = NUM_FRAMES / WORD_BITS;
   localparam int PHASES     = 9;

   logic                clock;
   logic                reset            = 1'b1;
   logic                req_valid        = 1'b0;
   logic                req_ready;
   req_type             req_payload      = '0;
   logic                rsp_valid;
   logic                rsp_ready        = 1'b0;
   rsp_type             rsp_payload;
   logic                csr_write_enable = 1'b0;
   logic [LIMIT_W-1:0]  csr_write_data   = '0;

   // Shadow of the allocator state
   logic [WORD_BITS-1:0] frame_map [WORD_COUNT];
   logic [LIMIT_W-1:0]   frame_limit;

   req_type queued_requests [$];
   rsp_type due_responses [$];

   int send_wait;
   int take_wait;
   int send_calm;
   int take_calm;
   int requests_sent;
   int responses_checked;
   int mismatch_count;
   int grant_count;
   int nofree_count;
   int range_count;
   int limit_settings;

   // Frame-count settings for the random part, with the item count for each
   int unsigned phase_limit [PHASES] = '{64, 33, 0, 8191, 96, 1, 200, 32, 4096};
   int unsigned phase_items [PHASES] = '{220, 200, 40, 200, 240, 60, 240, 200, 300};

   frame_bitmap_allocator_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Apply one request to the shadow bitmap and return the response it must produce
   function automatic rsp_type apply_frame_op(req_type r);
      rsp_type     res;
      int unsigned span;
      int unsigned whole;
      int unsigned frame;
      bit          found;
      res   = '0;
      found = 1'b0;
      span  = (frame_limit > NUM_FRAMES) ? NUM_FRAMES : frame_limit;
      whole = span / WORD_BITS;
      frame = r.frame_address / PAGE_BYTES;
      if (r.action == ACT_ALLOC) begin
         // take the lowest clear bit among the whole words below the limit
         for (int w = 0; w < whole && !found; w++) begin
            for (int b = 0; b < WORD_BITS && !found; b++) begin
               if (!frame_map[w][b]) begin
                  frame_map[w][b]  = 1'b1;
                  res.frame_number = GRANT_W'(w * WORD_BITS + b);
                  found            = 1'b1;
               end
            end
         end
         if (found) begin
            grant_count++;
         end else begin
            res.status = STAT_NOFREE;
         end
      end else if (frame >= span) begin
         res.status = STAT_RANGE;
         if (r.action == ACT_TEST) begin
            res.in_use = 1'b1;
         end
      end else begin
         case (r.action)
            ACT_MARK: begin
               frame_map[frame / WORD_BITS][frame % WORD_BITS] = 1'b1;
            end
            ACT_FREE: begin
               frame_map[frame / WORD_BITS][frame % WORD_BITS] = 1'b0;
            end
            default: begin
               res.in_use = frame_map[frame / WORD_BITS][frame % WORD_BITS];
            end
         endcase
      end
      return res;
   endfunction

   // Draw the idle cycles before the next transfer, with runs of back-to-back transfers
   function automatic int draw_pause(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm = $urandom_range(8, 40);
         return 0;
      end
      return $urandom_range(0, 12);
   endfunction

   function automatic req_type random_request(int unsigned span);
      req_type     r;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         r.action = ACT_ALLOC;
      end else if (pick < 50) begin
         r.action = ACT_MARK;
      end else if (pick < 75) begin
         r.action = ACT_FREE;
      end else begin
         r.action = ACT_TEST;
      end
      // mostly frames around the managed range, sometimes any address at all
      if ($urandom_range(0, 4) == 0) begin
         r.frame_address = $urandom;
      end else begin
         r.frame_address = $urandom_range(0, span + 3) * PAGE_BYTES
                           + $urandom_range(0, PAGE_BYTES - 1);
      end
      return r;
   endfunction

   task automatic queue_request(logic [1:0] action, logic [ADDR_W-1:0] address);
      req_type r;
      r.action        = action;
      r.frame_address = address;
      queued_requests.push_back(r);
   endtask

   // Hold until every queued request is sent and every response has come back
   task automatic wait_idle();
      do begin
         @(negedge clock);
      end while (queued_requests.size() != 0 || req_valid || due_responses.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_frame_limit(int unsigned value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= LIMIT_W'(value);
      frame_limit       = LIMIT_W'(value);
      limit_settings++;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   // Request driver: present queued items, predict each one at its transfer
   always @(posedge clock) begin : drive_requests
      int gap;
      if (reset) begin
         req_valid <= 1'b0;
         send_wait <= 0;
      end else if (req_valid && req_ready) begin
         due_responses.push_back(apply_frame_op(req_payload));
         requests_sent++;
         gap = draw_pause(send_calm);
         if (gap == 0 && queued_requests.size() != 0) begin
            req_payload <= queued_requests.pop_front();
         end else begin
            req_valid <= 1'b0;
            send_wait <= (gap == 0) ? 0 : gap - 1;
         end
      end else if (!req_valid) begin
         if (send_wait != 0) begin
            send_wait <= send_wait - 1;
         end else if (queued_requests.size() != 0) begin
            req_payload <= queued_requests.pop_front();
            req_valid   <= 1'b1;
         end
      end
   end

   // Response monitor: compare each transfer with the oldest prediction, stall at random
   always @(posedge clock) begin : check_responses
      rsp_type want;
      int      gap;
      if (reset) begin
         rsp_ready <= 1'b0;
         take_wait <= 0;
      end else if (rsp_valid && rsp_ready) begin
         if (due_responses.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("unexpected response: in_use=%0d frame=%0d status=%0d",
                        rsp_payload.in_use, rsp_payload.frame_number, rsp_payload.status);
            end
         end else begin
            want = due_responses.pop_front();
            responses_checked++;
            if (want.status == STAT_NOFREE) begin
               nofree_count++;
            end else if (want.status == STAT_RANGE) begin
               range_count++;
            end
            if (rsp_payload.in_use !== want.in_use
                || rsp_payload.frame_number !== want.frame_number
                || rsp_payload.status !== want.status) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("mismatch at response %0d: expected in_use=%0d frame=%0d status=%0d,",
                           responses_checked, want.in_use, want.frame_number, want.status);
                  $display("   got in_use=%0d frame=%0d status=%0d",
                           rsp_payload.in_use, rsp_payload.frame_number, rsp_payload.status);
               end
            end
         end
         gap = draw_pause(take_calm);
         if (gap != 0) begin
            rsp_ready <= 1'b0;
            take_wait <= gap - 1;
         end
      end else if (!rsp_ready) begin
         if (take_wait != 0) begin
            take_wait <= take_wait - 1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Stimulus sequence
   initial begin
      int unsigned span;
      foreach (frame_map[i]) frame_map[i] = '0;
      frame_limit = LIMIT_W'(4096);
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: default limit, extremes of the address and every action
      queue_request(ACT_TEST,  32'h0000_0000);
      queue_request(ACT_MARK,  32'h0000_0000);
      queue_request(ACT_TEST,  32'h0000_0FFF);
      queue_request(ACT_ALLOC, 32'hFFFF_FFFF);
      queue_request(ACT_FREE,  32'h0000_0FFF);
      queue_request(ACT_ALLOC, 32'h0000_0000);
      queue_request(ACT_TEST,  32'hFFFF_FFFF);
      queue_request(ACT_MARK,  32'hFFFF_FFFF);
      queue_request(ACT_FREE,  32'hFFFF_FFFF);
      queue_request(ACT_MARK,  32'h00FF_F000);
      queue_request(ACT_TEST,  32'h00FF_FFFF);
      queue_request(ACT_TEST,  32'h0100_0000);
      queue_request(ACT_FREE,  32'h00FF_F000);
      queue_request(ACT_TEST,  32'h00FF_F000);
      queue_request(ACT_ALLOC, 32'h5555_AAAA);
      wait_idle();

      // empty frame range: everything refused
      set_frame_limit(0);
      queue_request(ACT_ALLOC, 32'h0000_0000);
      queue_request(ACT_TEST,  32'h0000_0000);
      queue_request(ACT_MARK,  32'h0000_0000);
      wait_idle();

      // limit above capacity saturates at the frame count
      set_frame_limit(8191);
      queue_request(ACT_TEST, 32'h00FF_F000);
      queue_request(ACT_TEST, 32'h0100_0000);
      wait_idle();

      // partial last word: reachable by mark and test, never granted
      set_frame_limit(40);
      queue_request(ACT_MARK,  32'h0002_7000);
      queue_request(ACT_TEST,  32'h0002_7000);
      queue_request(ACT_TEST,  32'h0002_8000);
      queue_request(ACT_ALLOC, 32'h0000_0000);
      wait_idle();

      // random phases, one frame count each
      for (int p = 0; p < PHASES; p++) begin
         set_frame_limit(phase_limit[p]);
         span = (phase_limit[p] > NUM_FRAMES) ? NUM_FRAMES : phase_limit[p];
         for (int n = 0; n < phase_items[p]; n++) begin
            queued_requests.push_back(random_request(span));
         end
         wait_idle();
      end

      repeat (20) @(posedge clock);
      $display("Ran %0d requests under %0d frame-count settings, %0d responses checked.",
               requests_sent, limit_settings, responses_checked);
      $display("Granted %0d frames, refused %0d allocations, hit %0d out-of-range frames.",
               grant_count, nofree_count, range_count);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Stop a hung run
   initial begin
      #40_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

### frame_bitmap_allocator_unit.f
design/fba_pkg.sv
design/fba_dpath.sv
design/fba_ctrl.sv
design/frame_bitmap_allocator_unit.sv
tb/frame_bitmap_allocator_unit_tb.sv
